// ===== rtl/core/smpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpc_pkg: shared types and constants of the source MAC frame counter
// Payload structs, command codes and table sizing defaults.
// ----------------------------------------------------------------------------
package smpc_pkg;

  localparam int unsigned TableEntriesDef = 256;
  localparam int unsigned MinFrameBytes   = 14;
  localparam int unsigned IntervalRst     = 20;
  localparam int unsigned CmdQDepth       = 2;
  localparam int unsigned MulticastBit    = 40;

  typedef enum logic [1:0] {
    FUNC_FRAME = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_READ  = 2'd3
  } func_e;

  typedef struct packed {
    func_e       func;
    logic [47:0] src_mac;
    logic [15:0] frame_len;
    logic        header_present;
    logic [7:0]  read_slot;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic        table_full;
    logic        slot_alloc;
    logic [7:0]  slot;
    logic        slot_valid;
    logic [47:0] slot_mac;
    logic [63:0] slot_count;
    logic [63:0] total_count;
    logic        cleared;
  } result_t;

  typedef enum logic [2:0] {
    CMD_DROP,
    CMD_FRAME,
    CMD_TICK,
    CMD_CLEAR,
    CMD_READ
  } cmd_e;

  typedef struct packed {
    cmd_e        kind;
    logic [47:0] mac;
    logic [7:0]  rslot;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_beat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_HIT,
    ST_READ
  } state_e;

endpackage

// ===== rtl/core/smpc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpc_front: input classification and command queue
// Sorts each input beat into a command and holds it in a short queue.
// ----------------------------------------------------------------------------
module smpc_front import smpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  item_t     item_i,
  output logic      full_o,
  output cmd_beat_t cmd_o,
  input  logic      cmd_pop_i
);

  localparam int unsigned PtrW = (CmdQDepth > 1) ? $clog2(CmdQDepth) : 1;
  localparam int unsigned CntW = $clog2(CmdQDepth + 1);

  cmd_t            q_mem_q [CmdQDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop, frame_ok;
  cmd_t            cmd_new;

  assign full_o  = (cnt_q == CntW'(CmdQDepth));
  assign do_push = push_i && !full_o;
  assign do_pop  = cmd_pop_i && (cnt_q != '0);

  assign frame_ok = item_i.header_present &&
                    (item_i.frame_len >= 16'(MinFrameBytes)) &&
                    !item_i.src_mac[MulticastBit];

  always_comb begin
    cmd_new.mac   = item_i.src_mac;
    cmd_new.rslot = item_i.read_slot;
    case (item_i.func)
      FUNC_FRAME: cmd_new.kind = frame_ok ? CMD_FRAME : CMD_DROP;
      FUNC_TICK:  cmd_new.kind = CMD_TICK;
      FUNC_CLEAR: cmd_new.kind = CMD_CLEAR;
      FUNC_READ:  cmd_new.kind = CMD_READ;
      default:    cmd_new.kind = CMD_DROP;
    endcase
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(CmdQDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(CmdQDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem_q[wr_ptr_q] <= cmd_new;
    end
  end

  assign cmd_o.valid = (cnt_q != '0);
  assign cmd_o.cmd   = q_mem_q[rd_ptr_q];

endmodule

// ===== rtl/core/smpc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpc_back: table engine
// Executes commands against the address/count table and registers results.
// ----------------------------------------------------------------------------
module smpc_back import smpc_pkg::*; #(
  parameter int unsigned TableEntries = TableEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_beat_t   cmd_i,
  output logic        cmd_pop_o,
  input  logic        cfg_valid_i,
  input  logic [15:0] cfg_data_i,
  output result_t     result_o,
  output logic        empty_o,
  input  logic        pop_i
);

  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = $clog2(TableEntries + 1);

  logic [47:0] mac_mem [TableEntries];
  logic [63:0] cnt_mem [TableEntries];

  state_e          state_q, state_d;
  cmd_t            cmd_q, cmd_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [CntW-1:0] used_q, used_d;
  logic [63:0]     total_q, total_d;
  logic [15:0]     ticks_q, ticks_d, ticks_inc;
  logic [15:0]     interval_q;
  result_t         res_q, res_d;
  logic            res_valid_q, produce;

  logic [IdxW-1:0] raddr, waddr;
  logic            we;
  logic [47:0]     wmac, rd_mac_q;
  logic [63:0]     wcnt, rd_cnt_q;

  logic start, hit, more, room;

  assign start     = (state_q == ST_IDLE) && cmd_i.valid && !res_valid_q;
  assign cmd_pop_o = start;
  assign hit       = (rd_mac_q == cmd_q.mac);
  assign more      = ({1'b0, idx_q} + 1'b1) < (IdxW+1)'(used_q);
  assign room      = used_q < CntW'(TableEntries);
  assign ticks_inc = ticks_q + 1'b1;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (cmd_i.cmd.kind == CMD_FRAME && used_q != '0) begin
            state_d = ST_SEARCH;
          end else if (cmd_i.cmd.kind == CMD_READ &&
                       32'(cmd_i.cmd.rslot) < 32'(used_q)) begin
            state_d = ST_READ;
          end
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          state_d = ST_HIT;
        end else if (!more) begin
          state_d = ST_IDLE;
        end
      end
      ST_HIT:  state_d = ST_IDLE;
      ST_READ: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and result.
  always_comb begin
    cmd_d   = cmd_q;
    idx_d   = idx_q;
    used_d  = used_q;
    total_d = total_q;
    ticks_d = ticks_q;
    res_d   = '0;
    produce = 1'b0;
    raddr   = idx_q;
    we      = 1'b0;
    waddr   = IdxW'(used_q);
    wmac    = cmd_q.mac;
    wcnt    = 64'd1;
    case (state_q)
      ST_IDLE: begin
        raddr = '0;
        if (start) begin
          cmd_d = cmd_i.cmd;
          idx_d = '0;
          case (cmd_i.cmd.kind)
            CMD_FRAME: begin
              total_d = total_q + 64'd1;
              if (used_q == '0) begin
                // Empty table: the first address goes straight into slot zero.
                we                = 1'b1;
                waddr             = '0;
                wmac              = cmd_i.cmd.mac;
                used_d            = CntW'(1);
                produce           = 1'b1;
                res_d.accepted    = 1'b1;
                res_d.slot_alloc  = 1'b1;
                res_d.slot_valid  = 1'b1;
                res_d.slot_mac    = cmd_i.cmd.mac;
                res_d.slot_count  = 64'd1;
                res_d.total_count = total_q + 64'd1;
              end
            end
            CMD_TICK: begin
              produce = 1'b1;
              if (ticks_inc >= interval_q) begin
                ticks_d       = '0;
                used_d        = '0;
                total_d       = '0;
                res_d.cleared = 1'b1;
              end else begin
                ticks_d           = ticks_inc;
                res_d.total_count = total_q;
              end
            end
            CMD_CLEAR: begin
              produce       = 1'b1;
              used_d        = '0;
              total_d       = '0;
              res_d.cleared = 1'b1;
            end
            CMD_READ: begin
              raddr = IdxW'(cmd_i.cmd.rslot);
              if (32'(cmd_i.cmd.rslot) >= 32'(used_q)) begin
                produce           = 1'b1;
                res_d.slot        = cmd_i.cmd.rslot;
                res_d.total_count = total_q;
              end
            end
            default: begin
              produce           = 1'b1;
              res_d.total_count = total_q;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        // Read data belongs to idx_q; on a miss with entries left the next one is fetched.
        if (hit) begin
          raddr = idx_q;
        end else if (more) begin
          raddr = idx_q + 1'b1;
          idx_d = idx_q + 1'b1;
        end else begin
          produce           = 1'b1;
          res_d.accepted    = 1'b1;
          res_d.total_count = total_q;
          if (room) begin
            we               = 1'b1;
            used_d           = used_q + 1'b1;
            res_d.slot_alloc = 1'b1;
            res_d.slot       = 8'(used_q);
            res_d.slot_valid = 1'b1;
            res_d.slot_mac   = cmd_q.mac;
            res_d.slot_count = 64'd1;
          end else begin
            res_d.table_full = 1'b1;
          end
        end
      end
      ST_HIT: begin
        we                = 1'b1;
        waddr             = idx_q;
        wmac              = rd_mac_q;
        wcnt              = rd_cnt_q + 64'd1;
        produce           = 1'b1;
        res_d.accepted    = 1'b1;
        res_d.slot        = 8'(idx_q);
        res_d.slot_valid  = 1'b1;
        res_d.slot_mac    = rd_mac_q;
        res_d.slot_count  = rd_cnt_q + 64'd1;
        res_d.total_count = total_q;
      end
      ST_READ: begin
        produce           = 1'b1;
        res_d.slot        = cmd_q.rslot;
        res_d.slot_valid  = 1'b1;
        res_d.slot_mac    = rd_mac_q;
        res_d.slot_count  = rd_cnt_q;
        res_d.total_count = total_q;
      end
      default: begin
        raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      total_q     <= '0;
      ticks_q     <= '0;
      interval_q  <= 16'(IntervalRst);
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      total_q <= total_d;
      ticks_q <= ticks_d;
      if (cfg_valid_i) begin
        interval_q <= cfg_data_i;
      end
      if (produce) begin
        res_valid_q <= 1'b1;
      end else if (pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    idx_q <= idx_d;
    if (produce) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mac_mem[waddr] <= wmac;
      cnt_mem[waddr] <= wcnt;
    end
    rd_mac_q <= mac_mem[raddr];
    rd_cnt_q <= cnt_mem[raddr];
  end

  assign result_o = res_q;
  assign empty_o  = !res_valid_q;

endmodule

// ===== rtl/core/source_mac_packet_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_mac_packet_counter: per-source MAC frame statistics table
// Counts accepted frames in total and per source address, with periodic clear.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  input     push / full               item_i    (item_t)
//  result    empty / pop               result_o  (result_t)
//  config    cfg_valid_i / cfg_ready_o cfg_data_i (reset interval in ticks)
//
// A drop, tick, clear or read of a free slot is answered from the idle state;
// a read of a slot in use goes through the read state first.
// A frame scans the table one entry a cycle through the memory read port,
// over the slots in use, at most TableEntries of them.
// Reset clears the fill count, so no clearing pass is needed.
// A two-beat command queue lets input beats land while a result waits on pop.
module source_mac_packet_counter import smpc_pkg::*; #(
  parameter int unsigned TableEntries = TableEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  item_t       item_i,
  output logic        empty,
  input  logic        pop,
  output result_t     result_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  cmd_beat_t cmd;
  logic      cmd_pop;

  assign cfg_ready_o = 1'b1;

  smpc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .item_i    (item_i),
    .full_o    (full),
    .cmd_o     (cmd),
    .cmd_pop_i (cmd_pop)
  );

  smpc_back #(
    .TableEntries (TableEntries)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .result_o    (result_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule

// ===== rtl/core/smpc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpc_checker: port-level checks of the frame counter
// Watches the result queue and the relations among result fields.
// ----------------------------------------------------------------------------
module smpc_checker import smpc_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    empty,
  input logic    pop,
  input result_t result_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("result changed while waiting for pop");

  a_clear_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.cleared) |-> (result_o.total_count == 64'd0))
    else $error("clear beat shows a nonzero total");

  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !result_o.accepted) |-> (!result_o.table_full && !result_o.slot_alloc))
    else $error("dropped beat flags a table update");

  a_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.slot_alloc) |->
      (result_o.slot_valid && result_o.slot_count == 64'd1 && !result_o.table_full))
    else $error("new entry beat with wrong slot fields");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.table_full) |-> (!result_o.slot_valid && result_o.accepted))
    else $error("full table beat reports a slot");

endmodule

bind source_mac_packet_counter smpc_checker u_smpc_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);
